>>> rtl/ejtag_pracc_service_sequencer_macros.svh
// Assertion macros used by the checker file.
// No dependencies; expects signals clk and rst in the using scope.
`ifndef EJTAG_PRACC_SERVICE_SEQUENCER_MACROS_SVH
`define EJTAG_PRACC_SERVICE_SEQUENCER_MACROS_SVH

// Checked only outside reset.
`define EJPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define EJPS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ejps_pkg.sv
// Types and constants of the EJTAG processor-access service sequencer.
// No dependencies.
package ejps_pkg;

  // request function codes
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_SCAN  = 2'd1;
  localparam logic [1:0] FUNC_LOAD  = 2'd2;

  // instruction register codes
  localparam logic [4:0] IR_ADDRESS = 5'h08;
  localparam logic [4:0] IR_DATA    = 5'h09;
  localparam logic [4:0] IR_CONTROL = 5'h0a;

  // EJTAG control register bits
  localparam logic [31:0] CR_ROCC     = 32'h1 << 31;
  localparam logic [31:0] CR_PRNW     = 32'h1 << 19;
  localparam logic [31:0] CR_PRACC    = 32'h1 << 18;
  localparam logic [31:0] CR_PROBEN   = 32'h1 << 15;
  localparam logic [31:0] CR_PROBTRAP = 32'h1 << 14;
  localparam logic [31:0] CR_EJTAGBRK = 32'h1 << 12;
  localparam logic [31:0] CR_DM       = 32'h1 << 3;

  localparam logic [31:0] CTL_FIRST   = CR_ROCC | CR_PRACC | CR_PROBEN | CR_PROBTRAP | CR_EJTAGBRK;
  localparam logic [31:0] CTL_CLRROCC = CR_PRACC | CR_PROBEN | CR_PROBTRAP | CR_EJTAGBRK;
  localparam logic [31:0] CTL_POLL    = CR_ROCC | CR_PRACC | CR_PROBEN | CR_PROBTRAP;
  localparam logic [31:0] CTL_RELEASE = CR_ROCC | CR_PROBEN | CR_PROBTRAP;

  // session end status
  localparam logic [1:0] ST_RUNNING  = 2'd0;
  localparam logic [1:0] ST_NO_DM    = 2'd1;
  localparam logic [1:0] ST_DM_LOST  = 2'd2;
  localparam logic [1:0] ST_OUTRANGE = 2'd3;

  // register map (byte address bit 2 picks the register)
  localparam logic REG_PROGRAM_BASE  = 1'b0;
  localparam logic REG_PROGRAM_WORDS = 1'b1;

  localparam logic [31:0] PROGRAM_BASE_RST = 32'hff20_0200;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_FIRST    = 4'd1,
    PH_ROCC_CLR = 4'd2,
    PH_ROCC_SET = 4'd3,
    PH_DMCHECK  = 4'd4,
    PH_POLL     = 4'd5,
    PH_ADDR     = 4'd6,
    PH_WDATA    = 4'd7,
    PH_RDATA    = 4'd8,
    PH_RELEASE  = 4'd9
  } phase_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] captured;
    logic [3:0]  word_index;
  } ejps_in_t;

  typedef struct packed {
    logic        issue_scan;
    logic [4:0]  instr_code;
    logic [31:0] shift_out;
    logic        finished;
    logic [1:0]  end_status;
    logic        write_seen;
    logic [31:0] write_value;
  } ejps_out_t;

  // sequencer decision for one accepted request
  typedef struct packed {
    logic res_valid;  // request yields a result
    logic fetch;      // shift_out comes from the program store read
    logic mem_re;     // program store read enable
  } ejps_dec_t;

endpackage

>>> rtl/ejtag_pracc_service_sequencer.sv
// EJTAG processor-access service sequencer, top level.
// Depends on ejps_pkg, ejps_ctrl and ejps_store.
//
// Usage: a probe sends requests on the cmd channel (cmd_valid / cmd_stall / cmd).
// A start request opens a session and yields the first control-register scan.
// Each scan-result request carries the value captured by the previous scan and
// yields the next scan request, or the ending status, on the rsp channel
// (rsp_valid / rsp_stall / rsp). Load requests fill the program store and give
// no response; they may arrive at any time.
// Throughput: one request per cycle while cmd_stall is low. A response passes
// the middle stage, which holds the sequencer decision and the synchronous program
// store read, and then the response register.
// Stall: while rsp_stall holds a response, one more decided request waits in the
// middle stage and cmd_stall rises; nothing is dropped.
// Reset (synchronous rst) ends any session, empties both stages and restores the
// registers; the program store is not cleared and holds no valid bits, so the
// user must load a word before its fetch (not enforced). No clearing pass is run.
// A load followed by a fetch of the same word sees the new word, since the
// write lands at the edge before the read is issued.
// Registers (APB, pready always high): 0x0 program_base, 0x4 program_words.
module ejtag_pracc_service_sequencer #(
  parameter int PROGRAM_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  // request channel
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  ejps_pkg::ejps_in_t  cmd,
  // response channel
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output ejps_pkg::ejps_out_t rsp,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import ejps_pkg::*;

  localparam int AddrW = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;

  // configuration registers
  logic [31:0] program_base;
  logic [4:0]  program_words;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_PROGRAM_WORDS) ? 32'(program_words) : program_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      program_base  <= PROGRAM_BASE_RST;
      program_words <= '0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_PROGRAM_BASE:  program_base  <= pwdata;
        REG_PROGRAM_WORDS: program_words <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // handshake between the stages
  logic accept, s2_valid, s2_advance;

  assign s2_advance = s2_valid && !(rsp_valid && rsp_stall);
  assign cmd_stall  = s2_valid && rsp_valid && rsp_stall;
  assign accept     = cmd_valid && !cmd_stall;

  // sequencer
  ejps_out_t        dec_res;
  ejps_dec_t        dec;
  logic [AddrW-1:0] rd_addr;

  ejps_ctrl #(.PROGRAM_DEPTH(PROGRAM_DEPTH)) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .item          (cmd),
    .program_base  (program_base),
    .program_words (program_words),
    .res           (dec_res),
    .dec           (dec),
    .rd_addr       (rd_addr)
  );

  // program store: loads with an index beyond the depth are dropped
  logic [31:0]      widx32;
  logic             mem_we;
  logic [AddrW-1:0] waddr;
  logic [31:0]      rdata;

  assign widx32 = 32'(cmd.word_index);
  assign waddr  = widx32[AddrW-1:0];
  assign mem_we = accept && (cmd.func == FUNC_LOAD) && (widx32 < 32'(PROGRAM_DEPTH));

  ejps_store #(.PROGRAM_DEPTH(PROGRAM_DEPTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (cmd.captured),
    .re    (accept && dec.mem_re),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // middle stage: decided response waiting for the store read data
  logic      s2_fetch;
  ejps_out_t s2_item, s2_merged;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (accept) begin
      s2_valid <= dec.res_valid;
    end else if (s2_advance) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_item  <= dec_res;
      s2_fetch <= dec.fetch;
    end
  end

  always_comb begin
    s2_merged = s2_item;
    if (s2_fetch) begin
      s2_merged.shift_out = rdata;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s2_advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_advance) begin
      rsp <= s2_merged;
    end
  end

endmodule

>>> rtl/ejps_store.sv
// Program store: one write port, one read port, registered read data.
// Depends on nothing.
module ejps_store #(
  parameter int PROGRAM_DEPTH = 16,
  localparam int AddrW = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [31:0]      wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [31:0]      rdata
);

  logic [31:0] mem [PROGRAM_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/ejps_ctrl.sv
// Session state machine: decides the next scan request, or the ending status, for each accepted request.
// Depends on ejps_pkg.
module ejps_ctrl #(
  parameter int PROGRAM_DEPTH = 16,
  localparam int AddrW = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  ejps_pkg::ejps_in_t  item,
  input  logic [31:0]         program_base,
  input  logic [4:0]          program_words,
  output ejps_pkg::ejps_out_t res,
  output ejps_pkg::ejps_dec_t dec,
  output logic [AddrW-1:0]    rd_addr
);
  import ejps_pkg::*;

  phase_t      phase, phase_next;
  logic        access_is_write, access_is_write_next;
  logic [31:0] words32, depth32, limit, offset;
  logic        in_range;

  function automatic ejps_out_t scan_item(logic [4:0] code, logic [31:0] value);
    ejps_out_t r;
    r = '0;
    r.issue_scan = 1'b1;
    r.instr_code = code;
    r.shift_out  = value;
    return r;
  endfunction

  function automatic ejps_out_t end_item(logic [1:0] status);
    ejps_out_t r;
    r = '0;
    r.finished   = 1'b1;
    r.end_status = status;
    return r;
  endfunction

  // fetch window: offset below 4 * min(program_words, depth)
  assign words32  = 32'(program_words);
  assign depth32  = 32'(PROGRAM_DEPTH);
  assign limit    = ((words32 > depth32) ? depth32 : words32) << 2;
  assign offset   = item.captured - program_base;
  assign in_range = offset < limit;
  assign rd_addr  = offset[AddrW+1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      access_is_write <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      access_is_write <= access_is_write_next;
    end
  end

  always_comb begin
    phase_next           = phase;
    access_is_write_next = access_is_write;
    res                  = '0;
    dec                  = '0;
    unique case (item.func)
      FUNC_START: begin
        res           = scan_item(IR_CONTROL, CTL_FIRST);
        dec.res_valid = 1'b1;
        phase_next    = PH_FIRST;
      end
      FUNC_SCAN: begin
        unique case (phase)
          PH_FIRST: begin
            dec.res_valid = 1'b1;
            if ((item.captured & CR_ROCC) != '0) begin
              res        = scan_item(IR_CONTROL, CTL_CLRROCC);
              phase_next = PH_ROCC_CLR;
            end else begin
              res        = scan_item(IR_CONTROL, CTL_POLL);
              phase_next = PH_DMCHECK;
            end
          end
          PH_ROCC_CLR: begin
            dec.res_valid = 1'b1;
            res           = scan_item(IR_CONTROL, CTL_FIRST);
            phase_next    = PH_ROCC_SET;
          end
          PH_ROCC_SET: begin
            dec.res_valid = 1'b1;
            res           = scan_item(IR_CONTROL, CTL_POLL);
            phase_next    = PH_DMCHECK;
          end
          PH_DMCHECK: begin
            dec.res_valid = 1'b1;
            if ((item.captured & CR_DM) == '0) begin
              res        = end_item(ST_NO_DM);
              phase_next = PH_IDLE;
            end else begin
              res        = scan_item(IR_CONTROL, CTL_POLL);
              phase_next = PH_POLL;
            end
          end
          PH_POLL: begin
            dec.res_valid = 1'b1;
            if ((item.captured & CR_DM) == '0) begin
              res        = end_item(ST_DM_LOST);
              phase_next = PH_IDLE;
            end else if ((item.captured & CR_PRACC) != '0) begin
              access_is_write_next = (item.captured & CR_PRNW) != '0;
              res                  = scan_item(IR_ADDRESS, '0);
              phase_next           = PH_ADDR;
            end else begin
              res = scan_item(IR_CONTROL, CTL_POLL);
            end
          end
          PH_ADDR: begin
            dec.res_valid = 1'b1;
            if (access_is_write) begin
              res        = scan_item(IR_DATA, '0);
              phase_next = PH_WDATA;
            end else if (in_range) begin
              // data word is filled in from the registered store read in the middle stage
              res        = scan_item(IR_DATA, '0);
              dec.fetch  = 1'b1;
              dec.mem_re = 1'b1;
              phase_next = PH_RDATA;
            end else begin
              res        = end_item(ST_OUTRANGE);
              phase_next = PH_IDLE;
            end
          end
          PH_WDATA: begin
            dec.res_valid   = 1'b1;
            res             = scan_item(IR_CONTROL, CTL_RELEASE);
            res.write_seen  = 1'b1;
            res.write_value = item.captured;
            phase_next      = PH_RELEASE;
          end
          PH_RDATA: begin
            dec.res_valid = 1'b1;
            res           = scan_item(IR_CONTROL, CTL_RELEASE);
            phase_next    = PH_RELEASE;
          end
          PH_RELEASE: begin
            dec.res_valid = 1'b1;
            res           = scan_item(IR_CONTROL, CTL_POLL);
            phase_next    = PH_POLL;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
      default: begin
        // loads are handled by the store path; unused code is dropped
      end
    endcase
  end

endmodule

>>> rtl/ejps_checker.sv
// Port-level checks of the sequencer, bound to the top level.
// Depends on ejps_pkg and the macro header.
`include "ejtag_pracc_service_sequencer_macros.svh"

module ejps_checker (
  input logic                clk,
  input logic                rst,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input ejps_pkg::ejps_out_t rsp
);
  import ejps_pkg::*;

  `EJPS_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "stalled response changed")
  `EJPS_ASSERT(a_end_clean, rsp_valid && rsp.finished |-> !rsp.issue_scan && rsp.end_status != ST_RUNNING && !rsp.write_seen, "ending response carries scan fields")
  `EJPS_ASSERT(a_write_release, rsp_valid && rsp.write_seen |-> rsp.issue_scan && rsp.instr_code == IR_CONTROL && rsp.shift_out == CTL_RELEASE, "captured write not paired with release")
  `EJPS_ASSERT_ALWAYS(a_rst_empty, rst |=> !rsp_valid, "response after reset")

endmodule

bind ejtag_pracc_service_sequencer ejps_checker u_ejps_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

>>> tb/ejtag_pracc_service_sequencer_tb.sv
// Self-checking testbench of the EJTAG processor-access service sequencer.
// Depends on ejps_pkg and ejtag_pracc_service_sequencer; predicts every response
// in its own copy of the sequencer and checks it at the response port.
`timescale 1ns / 100ps

module ejtag_pracc_service_sequencer_tb;
  import ejps_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;   // no meaning, must be ignored
  localparam int STORE_DEPTH = 16;
  localparam int SETTLE      = 4;      // covers a trailing load
  localparam int QUIET_LIMIT = 2000;   // cycles with no handshake at all
  localparam int LONG_HOLD   = 60;
  localparam int MAX_REPORTS = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  ejps_in_t    cmd = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  ejps_out_t   rsp;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // requests waiting for the driver, responses waiting for the monitor
  ejps_in_t  probe_requests[$];
  ejps_out_t due_responses[$];

  // predictor state: register copies plus the sequencer's own state
  logic [31:0] cfg_base  = PROGRAM_BASE_RST;
  logic [4:0]  cfg_words = '0;
  phase_t      seq_phase = PH_IDLE;
  logic        seq_is_write = 1'b0;
  logic [31:0] prog_mirror [STORE_DEPTH];

  // idling knobs, set per phase of the run
  int unsigned gap_pct  = 0;
  int unsigned hold_pct = 0;
  bit          calm     = 1'b0;

  int unsigned queued     = 0;
  int unsigned fail_count = 0;
  int unsigned rsp_seen   = 0;
  int unsigned gap_left   = 0;
  int unsigned hold_left  = 0;
  int unsigned hold_at    = 300;   // response count that triggers the next long hold
  int unsigned quiet      = 0;

  always #4 clk = ~clk;

  ejtag_pracc_service_sequencer i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic ejps_out_t scan_of(logic [4:0] code, logic [31:0] value);
    ejps_out_t r;
    r = '0;
    r.issue_scan = 1'b1;
    r.instr_code = code;
    r.shift_out  = value;
    return r;
  endfunction

  function automatic ejps_out_t end_of(logic [1:0] status);
    ejps_out_t r;
    r = '0;
    r.finished   = 1'b1;
    r.end_status = status;
    return r;
  endfunction

  // Advances the predicted sequencer by one accepted request. Returns 1 when the
  // request yields a response, which is then in r.
  function automatic bit sequence_next(input ejps_in_t req, output ejps_out_t r);
    logic [31:0] offset;
    logic [6:0]  span;
    bit          gives;
    r = '0;
    gives = 1'b1;
    if (req.func == FUNC_START) begin
      // a start always reopens the session, running or not
      r = scan_of(IR_CONTROL, CTL_FIRST);
      seq_phase = PH_FIRST;
    end else if (req.func == FUNC_LOAD) begin
      prog_mirror[req.word_index] = req.captured;
      gives = 1'b0;
    end else if (req.func != FUNC_SCAN) begin
      gives = 1'b0;
    end else begin
      case (seq_phase)
        PH_FIRST: begin
          if ((req.captured & CR_ROCC) != 0) begin
            r = scan_of(IR_CONTROL, CTL_CLRROCC);
            seq_phase = PH_ROCC_CLR;
          end else begin
            r = scan_of(IR_CONTROL, CTL_POLL);
            seq_phase = PH_DMCHECK;
          end
        end
        PH_ROCC_CLR: begin
          r = scan_of(IR_CONTROL, CTL_FIRST);
          seq_phase = PH_ROCC_SET;
        end
        PH_ROCC_SET: begin
          r = scan_of(IR_CONTROL, CTL_POLL);
          seq_phase = PH_DMCHECK;
        end
        PH_DMCHECK: begin
          if ((req.captured & CR_DM) == 0) begin
            r = end_of(ST_NO_DM);
            seq_phase = PH_IDLE;
          end else begin
            r = scan_of(IR_CONTROL, CTL_POLL);
            seq_phase = PH_POLL;
          end
        end
        PH_POLL: begin
          if ((req.captured & CR_DM) == 0) begin
            r = end_of(ST_DM_LOST);
            seq_phase = PH_IDLE;
          end else if ((req.captured & CR_PRACC) != 0) begin
            seq_is_write = (req.captured & CR_PRNW) != 0;
            r = scan_of(IR_ADDRESS, '0);
            seq_phase = PH_ADDR;
          end else begin
            r = scan_of(IR_CONTROL, CTL_POLL);
          end
        end
        PH_ADDR: begin
          if (seq_is_write) begin
            r = scan_of(IR_DATA, '0);
            seq_phase = PH_WDATA;
          end else begin
            // word count saturates at the store depth; offset wraps mod 2^32
            span   = (cfg_words > 5'd16) ? 7'd64 : {cfg_words, 2'b00};
            offset = req.captured - cfg_base;
            if (offset < span) begin
              r = scan_of(IR_DATA, prog_mirror[offset[5:2]]);
              seq_phase = PH_RDATA;
            end else begin
              r = end_of(ST_OUTRANGE);
              seq_phase = PH_IDLE;
            end
          end
        end
        PH_WDATA: begin
          r = scan_of(IR_CONTROL, CTL_RELEASE);
          r.write_seen  = 1'b1;
          r.write_value = req.captured;
          seq_phase = PH_RELEASE;
        end
        PH_RDATA: begin
          r = scan_of(IR_CONTROL, CTL_RELEASE);
          seq_phase = PH_RELEASE;
        end
        PH_RELEASE: begin
          r = scan_of(IR_CONTROL, CTL_POLL);
          seq_phase = PH_POLL;
        end
        default: begin
          // idle or ended: scan results are dropped
          gives = 1'b0;
          seq_phase = PH_IDLE;
        end
      endcase
    end
    return gives;
  endfunction

  function automatic string describe(ejps_out_t r);
    return $sformatf("scan=%0b ir=%02h shift=%08h fin=%0b status=%0d wseen=%0b wval=%08h",
                     r.issue_scan, r.instr_code, r.shift_out, r.finished, r.end_status,
                     r.write_seen, r.write_value);
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: one request per free slot, random gaps between requests.
  // The prediction is made at the edge that accepts the request.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    ejps_out_t want;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        if (sequence_next(cmd, want)) due_responses.push_back(want);
      end
      // new payload only when the current one has gone or none is shown
      if (!cmd_valid || !cmd_stall) begin
        if (gap_left != 0) begin
          gap_left  = gap_left - 1;
          cmd_valid <= 1'b0;
        end else if (probe_requests.size() != 0) begin
          cmd       <= probe_requests.pop_front();
          cmd_valid <= 1'b1;
          if (!calm && $urandom_range(0, 99) < gap_pct) gap_left = $urandom_range(1, 17);
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Response monitor and receiver stall. Besides short random bursts it holds
  // off once in a while for a long stretch so the block backs up to its input.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    ejps_out_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_seen = rsp_seen + 1;
        if (due_responses.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: response with none pending: %s", $realtime, describe(rsp));
        end else begin
          want = due_responses.pop_front();
          if (rsp.issue_scan !== want.issue_scan || rsp.instr_code !== want.instr_code ||
              rsp.shift_out !== want.shift_out || rsp.finished !== want.finished ||
              rsp.end_status !== want.end_status || rsp.write_seen !== want.write_seen ||
              rsp.write_value !== want.write_value) begin
            fail_count = fail_count + 1;
            if (fail_count <= MAX_REPORTS) begin
              $display("%0t: response %0d mismatch", $realtime, rsp_seen);
              $display("  exp %s", describe(want));
              $display("  got %s", describe(rsp));
            end
          end
        end
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        rsp_stall <= 1'b1;
      end else if (!calm && rsp_seen >= hold_at) begin
        hold_left = LONG_HOLD - 1;
        hold_at   = (hold_at < 900) ? 900 : 32'hffff_ffff;
        rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < hold_pct) begin
        hold_left = $urandom_range(0, 16);
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // watchdog: any handshake on either channel restarts the count
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", quiet);
      $display("FAILURE");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  task automatic push_req(logic [1:0] f, logic [31:0] c, logic [3:0] w);
    ejps_in_t q;
    q.func       = f;
    q.captured   = c;
    q.word_index = w;
    probe_requests.push_back(q);
    if (f != FUNC_UNUSED) queued = queued + 1;
  endtask

  task automatic push_scan(logic [31:0] c);
    push_req(FUNC_SCAN, c, 4'($urandom_range(0, 15)));
  endtask

  // occasional load at an arbitrary point, rarer fully random request
  task automatic maybe_interject();
    if ($urandom_range(0, 19) == 0)
      push_req(FUNC_LOAD, $urandom, 4'($urandom_range(0, 15)));
    else if ($urandom_range(0, 59) == 0)
      push_req(2'($urandom_range(0, 3)), $urandom, 4'($urandom_range(0, 15)));
  endtask

  // One service session with random content. Mostly well formed: start,
  // optional reset-occurred clearing, DM check, then a few accesses each made of
  // polls, access, address, data and release. Sometimes ends early on purpose.
  task automatic add_session();
    logic [31:0] c;
    int unsigned eff;
    int unsigned k;
    push_req(FUNC_START, $urandom, 4'($urandom_range(0, 15)));
    c = $urandom;
    push_scan(c);
    if ((c & CR_ROCC) != 0) begin
      push_scan($urandom);
      push_scan($urandom);
    end
    maybe_interject();
    if ($urandom_range(0, 11) == 0) begin
      push_scan($urandom & ~CR_DM);
      return;
    end
    push_scan($urandom | CR_DM);
    repeat ($urandom_range(1, 6)) begin
      repeat ($urandom_range(0, 2)) push_scan(($urandom | CR_DM) & ~CR_PRACC);
      if ($urandom_range(0, 19) == 0) begin
        push_scan($urandom & ~CR_DM);
        return;
      end
      c = $urandom | CR_DM | CR_PRACC;
      push_scan(c);
      if ((c & CR_PRNW) != 0) begin
        push_scan($urandom);
      end else begin
        eff = (cfg_words > 16) ? 16 : cfg_words;
        if (eff == 0 || $urandom_range(0, 9) == 0) begin
          // just past the last word, or anywhere
          push_scan($urandom_range(0, 1) ? cfg_base + eff * 4 + $urandom_range(0, 3)
                                         : $urandom);
          return;
        end
        k = $urandom_range(0, eff - 1);
        push_scan(cfg_base + k * 4 + $urandom_range(0, 3));
      end
      maybe_interject();
      push_scan($urandom);   // data scan capture
      push_scan($urandom);   // release scan capture
    end
  endtask

  // block idle: nothing queued, shown or outstanding, then let the pipe settle
  task automatic drain();
    do @(negedge clk);
    while (probe_requests.size() != 0 || cmd_valid || due_responses.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic run_traffic(int unsigned goal);
    queued = 0;
    while (queued < goal) begin
      if ($urandom_range(0, 7) == 0) push_req(FUNC_LOAD, $urandom, 4'($urandom_range(0, 15)));
      else add_session();
    end
    drain();
  endtask

  task automatic write_reg(logic sel, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (sel == REG_PROGRAM_BASE) cfg_base = value;
    else cfg_words = value[4:0];
  endtask

  task automatic program_config(logic [31:0] base, logic [4:0] words);
    write_reg(REG_PROGRAM_BASE, base);
    write_reg(REG_PROGRAM_WORDS, {27'd0, words});
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, reset configuration (empty program).
    gap_pct  = 25;
    hold_pct = 25;
    // scan result with no session open, and the unused function code
    push_scan(32'hffff_ffff);
    push_req(FUNC_UNUSED, 32'hffff_ffff, 4'hf);
    // reset-occurred flag pending: clear and rearm, then debug mode absent
    push_req(FUNC_START, 32'h0, 4'h0);
    push_scan(32'hffff_ffff);
    push_scan(32'h0);
    push_scan(32'h0);
    push_scan(32'h0);
    // start twice (restart while running), then a target store
    push_req(FUNC_START, 32'hffff_ffff, 4'hf);
    push_req(FUNC_START, 32'h0, 4'h0);
    push_scan(32'h0);
    push_scan(CR_DM);
    push_scan(CR_DM);            // nothing pending yet: poll again
    push_scan(32'hffff_ffff);    // pending access, write direction
    push_scan(32'h0);            // address
    push_scan(32'hffff_ffff);    // stored word comes back on the release scan
    push_scan(32'h0);
    // fetch while the program is empty: outside the program
    push_scan(CR_DM | CR_PRACC);
    push_scan(PROGRAM_BASE_RST);
    // debug mode drops while polling
    push_req(FUNC_START, 32'h0, 4'h0);
    push_scan(32'h0);
    push_scan(CR_DM);
    push_scan(32'h0);
    push_req(FUNC_LOAD, 32'h0, 4'h0);
    push_req(FUNC_LOAD, 32'hffff_ffff, 4'hf);
    drain();

    // Fill the whole store before any fetch can land in range; meanwhile
    // every fetch still runs out of the (empty) program.
    gap_pct  = 0;
    hold_pct = 0;
    for (int i = 0; i < STORE_DEPTH; i++) push_req(FUNC_LOAD, $urandom, i[3:0]);
    run_traffic(80);

    gap_pct  = 40;
    hold_pct = 40;
    program_config(32'h0, 5'd16);
    run_traffic(250);

    // base at the top of the space: offsets wrap; count above depth saturates
    gap_pct  = 15;
    hold_pct = 60;
    program_config(32'hffff_ffff, 5'd31);
    run_traffic(250);

    gap_pct  = 60;
    hold_pct = 10;
    program_config($urandom, 5'($urandom_range(1, 15)));
    run_traffic(250);

    gap_pct  = 30;
    hold_pct = 30;
    program_config($urandom, 5'd0);
    run_traffic(250);

    // closing stretch at full rate on both sides
    calm = 1'b1;
    program_config($urandom, 5'd16);
    run_traffic(250);

    if (fail_count == 0 && due_responses.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/ejps_pkg.sv
rtl/ejps_store.sv
rtl/ejps_ctrl.sv
rtl/ejtag_pracc_service_sequencer.sv
rtl/ejps_checker.sv
tb/ejtag_pracc_service_sequencer_tb.sv
